// ----- hw/rtl/cwpg_pkg.sv -----
// Shared types and constants for the context window pair generator.
`default_nettype none

package cwpg_pkg;

    localparam int WORD_W     = 20;
    localparam int IDX_W      = 23;
    localparam int KIND_W     = 3;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_ADDR_W = 2;
    localparam int WIN_W      = 3;
    // covers up to 15 left-context words and 31 context positions
    localparam int LEFT_W     = 4;
    localparam int CNT_W      = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VOCAB  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_WORD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CTX  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WCTX = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LR   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RR   = 3'd5;

    typedef struct packed {
        logic [WIN_W-1:0]      half_width;
        logic [CFG_DATA_W-1:0] vocab;
        logic                  one_step;
    } cfg_t;

    // One centre word to expand; context words travel alongside, first valid first
    typedef struct packed {
        logic [WORD_W-1:0]     centre;
        logic [CFG_DATA_W-1:0] vocab;
        logic [IDX_W-1:0]      base_off;
        logic [LEFT_W-1:0]     left_cnt;
        logic [CNT_W-1:0]      ctx_cnt;
        logic                  one_step;
    } job_hdr_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/context_window_pair_generator_unit.sv -----
// A centre job passes from the front through the job queue to the back end's output register.
// One result per cycle while the outputs are empty or popped; the single coordinate expander in
//   the back end takes a new centre only once the previous one has emitted its last result.
// Words are taken every cycle while the two-entry job queue between front and back has room.
// Reset: window empty, window 2, vocabulary 65536, two-step mode; window words are not cleared.
`default_nettype none

module context_window_pair_generator_unit #(
    parameter int MAX_WINDOW     = 4,
    parameter int MAX_VOCABULARY = 1048576
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                action,
    input  wire logic [cwpg_pkg::WORD_W-1:0]         word_id,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [cwpg_pkg::KIND_W-1:0]              matrix_kind,
    output logic [cwpg_pkg::IDX_W-1:0]               row_index,
    output logic [cwpg_pkg::IDX_W-1:0]               col_index,
    output logic                                     last,
    input  wire logic                                cfg_write,
    input  wire logic [cwpg_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  wire logic [cwpg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import cwpg_pkg::*;

    localparam int CTX_N   = 2 * MAX_WINDOW;
    localparam int Q_W     = $bits(job_hdr_t) + CTX_N * WORD_W;
    localparam int Q_DEPTH = 2;

    localparam logic [WIN_W-1:0] WIN_MAX =
        (MAX_WINDOW > (2**WIN_W - 1)) ? {WIN_W{1'b1}} : WIN_W'(MAX_WINDOW);
    localparam logic [WIN_W-1:0] WIN_RST = (MAX_WINDOW < 2) ? WIN_W'(MAX_WINDOW) : WIN_W'(2);
    localparam logic [CFG_DATA_W-1:0] VOCAB_MAX =
        (MAX_VOCABULARY > (2**CFG_DATA_W - 1)) ? {CFG_DATA_W{1'b1}}
                                               : CFG_DATA_W'(MAX_VOCABULARY);
    localparam logic [CFG_DATA_W-1:0] VOCAB_RST =
        (MAX_VOCABULARY < 65536) ? VOCAB_MAX : CFG_DATA_W'(65536);

    cfg_t                         cfg_reg;
    cfg_t                         cfg_next;
    logic                         win_clear;
    logic [WIN_W-1:0]             win_raw;
    logic [WIN_W-1:0]             win_sat;
    logic [CFG_DATA_W-1:0]        voc_sat;

    logic                         take;
    logic                         job_valid;
    job_hdr_t                     front_hdr;
    logic [CTX_N-1:0][WORD_W-1:0] front_ctx;
    job_hdr_t                     back_hdr;
    logic [CTX_N-1:0][WORD_W-1:0] back_ctx;
    logic [Q_W-1:0]               q_wdata;
    logic [Q_W-1:0]               q_rdata;
    logic                         q_full;
    logic                         q_empty;
    logic                         job_take;
    logic                         res_valid;
    result_t                      res;

    // out-of-range writes clamp into the supported range
    assign win_raw = cfg_data[WIN_W-1:0];
    assign win_sat = (win_raw == '0) ? WIN_W'(1) : ((win_raw > WIN_MAX) ? WIN_MAX : win_raw);
    assign voc_sat = (cfg_data == '0) ? CFG_DATA_W'(1)
                                      : ((cfg_data > VOCAB_MAX) ? VOCAB_MAX : cfg_data);

    always_comb
    begin
        cfg_next  = cfg_reg;
        win_clear = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW:
                begin
                    cfg_next.half_width = win_sat;
                    win_clear           = 1'b1;
                end
                REG_VOCAB:
                begin
                    cfg_next.vocab = voc_sat;
                end
                REG_MODE:
                begin
                    cfg_next.one_step = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_width <= WIN_RST;
            cfg_reg.vocab      <= VOCAB_RST;
            cfg_reg.one_step   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full = q_full;
    assign take = push && !q_full;

    cwpg_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .action    (action),
        .word_id   (word_id),
        .cfg       (cfg_reg),
        .win_clear (win_clear),
        .job_valid (job_valid),
        .job_hdr   (front_hdr),
        .job_ctx   (front_ctx)
    );

    assign q_wdata = {front_hdr, front_ctx};
    assign {back_hdr, back_ctx} = q_rdata;

    cwpg_queue #(
        .DATA_W (Q_W),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (job_take),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    cwpg_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!q_empty),
        .job_hdr   (back_hdr),
        .job_ctx   (back_ctx),
        .job_take  (job_take),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty       = !res_valid;
    assign matrix_kind = res.kind;
    assign row_index   = res.row;
    assign col_index   = res.col;
    assign last        = res.last;

endmodule

`default_nettype wire

// ----- hw/rtl/cwpg_queue.sv -----
// Small register queue that carries centre jobs from the front to the back.
`default_nettype none

module cwpg_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output logic [DATA_W-1:0]      rd_data,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cwpg_front.sv -----
// Front end: holds the word window, decides when a centre is due and builds its job.
`default_nettype none

module cwpg_front #(
    parameter int MAX_WINDOW = 4
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         take,
    input  wire logic                                         action,
    input  wire logic [cwpg_pkg::WORD_W-1:0]                  word_id,
    input  wire cwpg_pkg::cfg_t                               cfg,
    input  wire logic                                         win_clear,
    output logic                                              job_valid,
    output cwpg_pkg::job_hdr_t                                job_hdr,
    output logic [2*MAX_WINDOW-1:0][cwpg_pkg::WORD_W-1:0]     job_ctx
);

    import cwpg_pkg::*;

    localparam int SLOTS  = 2 * MAX_WINDOW + 1;
    localparam int CTX_N  = 2 * MAX_WINDOW;
    localparam int HELD_W = $clog2(SLOTS + 1);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int B_W    = $clog2(MAX_WINDOW + 1);

    logic [SLOTS-1:0][WORD_W-1:0] win_reg;
    logic [SLOTS-1:0][WORD_W-1:0] win_next;
    logic [SLOTS-1:0][WORD_W-1:0] win_wr;
    logic [HELD_W-1:0]            held_reg;
    logic [HELD_W-1:0]            held_next;
    logic [HELD_W-1:0]            held_wr;
    logic [B_W-1:0]               left_reg;
    logic [B_W-1:0]               left_next;

    logic [HELD_W-1:0] left_ext;
    logic [HELD_W-1:0] w_ext;
    logic [HELD_W-1:0] avail;
    logic [HELD_W-1:0] after_cnt;
    logic              pending;
    logic              fire;
    logic [SLOT_W-1:0] centre_idx;
    logic [WIN_W-1:0]  lo_pos;

    assign left_ext   = HELD_W'(left_reg);
    assign w_ext      = HELD_W'(cfg.half_width);
    assign avail      = held_wr - left_ext;
    assign after_cnt  = avail - HELD_W'(1);
    assign pending    = (held_wr > left_ext);
    // a push fires once the full right context is in, a flush whenever a centre waits
    assign fire       = take && pending && (action || (avail > w_ext));
    assign centre_idx = SLOT_W'(left_reg);
    assign lo_pos     = cfg.half_width - WIN_W'(left_reg);

    always_comb
    begin
        win_wr  = win_reg;
        held_wr = held_reg;
        if (!action && (held_reg < HELD_W'(SLOTS)))
        begin
            win_wr[held_reg[SLOT_W-1:0]] = word_id;
            held_wr = held_reg + HELD_W'(1);
        end
    end

    // context words in offset order, skipping the centre
    always_comb
    begin
        for (int k = 0; k < CTX_N; k++)
        begin
            job_ctx[k] = (k < int'(left_reg)) ? win_wr[k] : win_wr[k+1];
        end
    end

    assign job_valid         = fire;
    assign job_hdr.centre    = win_wr[centre_idx];
    assign job_hdr.vocab     = cfg.vocab;
    assign job_hdr.base_off  = IDX_W'(cfg.vocab) * IDX_W'(lo_pos);
    assign job_hdr.left_cnt  = LEFT_W'(left_reg);
    assign job_hdr.ctx_cnt   = CNT_W'(left_reg) + CNT_W'(after_cnt);
    assign job_hdr.one_step  = cfg.one_step;

    always_comb
    begin
        win_next  = win_reg;
        held_next = held_reg;
        left_next = left_reg;
        if (win_clear)
        begin
            held_next = '0;
            left_next = '0;
        end
        else if (take)
        begin
            if (fire)
            begin
                if (left_ext < w_ext)
                begin
                    win_next  = win_wr;
                    held_next = held_wr;
                    left_next = left_reg + B_W'(1);
                end
                else
                begin
                    for (int i = 0; i < SLOTS - 1; i++)
                    begin
                        win_next[i] = win_wr[i+1];
                    end
                    win_next[SLOTS-1] = win_wr[SLOTS-1];
                    held_next = held_wr - HELD_W'(1);
                end
            end
            else if (action)
            begin
                // flush with nothing pending: a new stream starts
                held_next = '0;
                left_next = '0;
            end
            else
            begin
                win_next  = win_wr;
                held_next = held_wr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            left_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    a_left_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        HELD_W'(left_reg) <= HELD_W'(cfg.half_width))
        else $error("left context count exceeds window half width");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_W'(SLOTS) && (held_reg <= left_ext + w_ext))
        else $error("window holds more words than a centre can use");

    a_job_size: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (job_hdr.ctx_cnt <= CNT_W'(2) * CNT_W'(cfg.half_width)))
        else $error("job has more context positions than the window allows");

endmodule

`default_nettype wire

// ----- hw/rtl/cwpg_back.sv -----
// Back end: walks one centre job and emits its coordinates, one per cycle while the output is free or popped.
`default_nettype none

module cwpg_back #(
    parameter int MAX_WINDOW = 4
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         job_avail,
    input  wire cwpg_pkg::job_hdr_t                           job_hdr,
    input  wire logic [2*MAX_WINDOW-1:0][cwpg_pkg::WORD_W-1:0] job_ctx,
    output logic                                              job_take,
    output logic                                              res_valid,
    output cwpg_pkg::result_t                                 res,
    input  wire logic                                         res_pop
);

    import cwpg_pkg::*;

    localparam int CTX_N = 2 * MAX_WINDOW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WORD = 3'd1;
    localparam logic [2:0] ST_PAIR = 3'd2;
    localparam logic [2:0] ST_CTX  = 3'd3;
    localparam logic [2:0] ST_WCTX = 3'd4;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    job_hdr_t                     hdr_reg;
    job_hdr_t                     hdr_next;
    logic [CTX_N-1:0][WORD_W-1:0] row_sh_reg;
    logic [CTX_N-1:0][WORD_W-1:0] row_sh_next;
    logic [CTX_N-1:0][WORD_W-1:0] col_sh_reg;
    logic [CTX_N-1:0][WORD_W-1:0] col_sh_next;
    logic [CTX_N-1:0][WORD_W-1:0] row_shift;
    logic [CTX_N-1:0][WORD_W-1:0] col_shift;
    logic [CNT_W-1:0]             k1_reg;
    logic [CNT_W-1:0]             k1_next;
    logic [CNT_W-1:0]             k2_reg;
    logic [CNT_W-1:0]             k2_next;
    // off1: vocab*p1; off1s: vocab*p1 on the left side, vocab*(p1-w) on the right
    logic [IDX_W-1:0]             off1_reg;
    logic [IDX_W-1:0]             off1_next;
    logic [IDX_W-1:0]             off1s_reg;
    logic [IDX_W-1:0]             off1s_next;
    logic [IDX_W-1:0]             colo_reg;
    logic [IDX_W-1:0]             colo_next;
    result_t                      out_reg;
    result_t                      out_next;
    logic                         ovalid_reg;
    logic                         ovalid_next;

    logic             adv;
    logic [IDX_W-1:0] vocab_ext;
    logic [IDX_W-1:0] word1;
    logic [IDX_W-1:0] word2;
    logic [IDX_W-1:0] centre_ext;
    logic [IDX_W-1:0] row1;
    logic [IDX_W-1:0] off1s_step;
    logic [CNT_W-1:0] left_cnt;
    logic [CNT_W-1:0] last_k;
    logic             left1;
    logic             left2;
    logic             last_k1;
    logic             last_k2;

    assign adv        = (state_reg != ST_IDLE) && (!ovalid_reg || res_pop);
    assign job_take   = (state_reg == ST_IDLE) && job_avail;
    assign vocab_ext  = IDX_W'(hdr_reg.vocab);
    assign word1      = IDX_W'(row_sh_reg[0]);
    assign word2      = IDX_W'(col_sh_reg[0]);
    assign centre_ext = IDX_W'(hdr_reg.centre);
    assign row1       = word1 + off1_reg;
    assign left_cnt   = CNT_W'(hdr_reg.left_cnt);
    assign last_k     = hdr_reg.ctx_cnt - CNT_W'(1);
    assign left1      = (k1_reg < left_cnt);
    assign left2      = (k2_reg < left_cnt);
    assign last_k1    = (k1_reg == last_k);
    assign last_k2    = (k2_reg == last_k);
    assign off1s_step = ((k1_reg + CNT_W'(1)) == left_cnt) ? '0 : off1s_reg + vocab_ext;

    always_comb
    begin
        for (int i = 0; i < CTX_N - 1; i++)
        begin
            row_shift[i] = row_sh_reg[i+1];
            col_shift[i] = col_sh_reg[i+1];
        end
        row_shift[CTX_N-1] = row_sh_reg[CTX_N-1];
        col_shift[CTX_N-1] = col_sh_reg[CTX_N-1];
    end

    always_comb
    begin
        state_next  = state_reg;
        hdr_next    = hdr_reg;
        row_sh_next = row_sh_reg;
        col_sh_next = col_sh_reg;
        k1_next     = k1_reg;
        k2_next     = k2_reg;
        off1_next   = off1_reg;
        off1s_next  = off1s_reg;
        colo_next   = colo_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        if (res_pop)
        begin
            ovalid_next = 1'b0;
        end
        if (adv)
        begin
            ovalid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (job_take)
                begin
                    hdr_next    = job_hdr;
                    row_sh_next = job_ctx;
                    state_next  = ST_WORD;
                end
            end
            ST_WORD:
            begin
                if (adv)
                begin
                    out_next.kind = KIND_WORD;
                    out_next.row  = centre_ext;
                    out_next.col  = '0;
                    out_next.last = (hdr_reg.ctx_cnt == '0);
                    if (hdr_reg.ctx_cnt == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k1_next     = '0;
                        k2_next     = '0;
                        off1_next   = hdr_reg.base_off;
                        // no left context means the first position is the first right one
                        off1s_next  = (hdr_reg.left_cnt == '0) ? '0 : hdr_reg.base_off;
                        colo_next   = (hdr_reg.left_cnt == '0) ? '0 : hdr_reg.base_off;
                        col_sh_next = row_sh_reg;
                        state_next  = hdr_reg.one_step ? ST_CTX : ST_PAIR;
                    end
                end
            end
            ST_PAIR:
            begin
                if (adv)
                begin
                    out_next.kind = left1 ? (left2 ? KIND_LL : KIND_LR) : KIND_RR;
                    out_next.row  = word1 + (left1 ? off1_reg : off1s_reg);
                    out_next.col  = word2 + colo_reg;
                    out_next.last = 1'b0;
                    if (last_k2)
                    begin
                        state_next = ST_WCTX;
                    end
                    else
                    begin
                        k2_next     = k2_reg + CNT_W'(1);
                        col_sh_next = col_shift;
                        colo_next   = ((k2_reg + CNT_W'(1)) == left_cnt) ? '0
                                                                         : colo_reg + vocab_ext;
                    end
                end
            end
            ST_CTX:
            begin
                if (adv)
                begin
                    out_next.kind = KIND_CTX;
                    out_next.row  = row1;
                    out_next.col  = '0;
                    out_next.last = 1'b0;
                    state_next    = ST_WCTX;
                end
            end
            ST_WCTX:
            begin
                if (adv)
                begin
                    out_next.kind = KIND_WCTX;
                    out_next.row  = centre_ext;
                    out_next.col  = row1;
                    out_next.last = last_k1;
                    if (last_k1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k1_next     = k1_reg + CNT_W'(1);
                        k2_next     = k1_reg + CNT_W'(1);
                        row_sh_next = row_shift;
                        col_sh_next = row_shift;
                        off1_next   = off1_reg + vocab_ext;
                        off1s_next  = off1s_step;
                        colo_next   = off1s_step;
                        state_next  = hdr_reg.one_step ? ST_CTX : ST_PAIR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg    <= hdr_next;
        row_sh_reg <= row_sh_next;
        col_sh_reg <= col_sh_next;
        k1_reg     <= k1_next;
        k2_reg     <= k2_next;
        off1_reg   <= off1_next;
        off1s_reg  <= off1s_next;
        colo_reg   <= colo_next;
        out_reg    <= out_next;
    end

    assign res_valid = ovalid_reg;
    assign res       = out_reg;

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR) |-> (k2_reg >= k1_reg) && (k2_reg < hdr_reg.ctx_cnt))
        else $error("pair walk outside the upper triangle");

    a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (state_reg == ST_WCTX) && last_k1)
        |=> (state_reg == ST_IDLE) && ovalid_reg && out_reg.last)
        else $error("final word-context pair did not close the job");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR || state_reg == ST_CTX || state_reg == ST_WCTX)
        |-> (hdr_reg.ctx_cnt != '0) && (k1_reg < hdr_reg.ctx_cnt))
        else $error("context walk with no context positions");

endmodule

`default_nettype wire
